// ----- hw/rtl/twa_pkg.sv -----
// Shared types and constants for the trimmed window average block.
`timescale 1ns / 1ps

package twa_pkg;

    localparam int SAMPLE_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIM,
        ST_DIV,
        ST_OUT
    } t_back_state;

endpackage

// ----- hw/rtl/twa_front.sv -----
// Front end: takes sample requests, keeps the sample history, forms each window.
`timescale 1ns / 1ps

module twa_front #(
    parameter int WINDOW = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_sample_valid,
    input  twa_pkg::t_sample                        i_sample_in,
    output logic                                    o_sample_stall,
    input  logic                                    i_queue_full,
    output logic                                    o_push,
    output logic [WINDOW-1:0][twa_pkg::SAMPLE_W-1:0] o_window
);
    import twa_pkg::*;

    logic [WINDOW-2:0][SAMPLE_W-1:0] r_hist;
    logic [WINDOW-2:0][SAMPLE_W-1:0] n_hist;
    logic                            accept;

    assign o_sample_stall = i_queue_full;
    assign accept         = i_sample_valid & ~i_queue_full;
    assign o_push         = accept;
    // entry 0 is the new sample, then history newest first
    assign o_window       = {r_hist, i_sample_in};

    always_comb begin
        n_hist = r_hist;
        if (accept) begin
            n_hist = {r_hist[WINDOW-3:0], i_sample_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else begin
            r_hist <= n_hist;
        end
    end

endmodule

// ----- hw/rtl/twa_queue.sv -----
// Two-entry window queue between the front end and the back end.
`timescale 1ns / 1ps

module twa_queue #(
    parameter int DATA_W = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/twa_back.sv -----
// Back end: scans a window for sum, max and min, trims, divides, holds the result.
`timescale 1ns / 1ps

module twa_back #(
    parameter int WINDOW = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic [WINDOW-1:0][twa_pkg::SAMPLE_W-1:0] i_window,
    output logic                                    o_pop,
    output logic                                    o_average_valid,
    output twa_pkg::t_sample                        o_average_out,
    input  logic                                    i_average_stall
);
    import twa_pkg::*;

    localparam int SUM_W   = $clog2(WINDOW) + SAMPLE_W;
    localparam int MAG_W   = SUM_W - 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    // exact reciprocal for division of a MAG_W-bit magnitude by WINDOW - 2
    localparam int DIV_SH  = $clog2(WINDOW - 2);
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam longint RECIP_L = ((longint'(1) << (MAG_W + DIV_SH)) + longint'(WINDOW - 3))
                               / longint'(WINDOW - 2);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};

    t_back_state                     r_state, n_state;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic [WINDOW-1:0][SAMPLE_W-1:0] r_win, n_win;
    logic signed [SUM_W-1:0]         r_sum, n_sum;
    t_sample                         r_hi, n_hi;
    t_sample                         r_lo, n_lo;
    logic                            r_neg, n_neg;
    logic [MAG_W-1:0]                r_mag, n_mag;
    t_sample                         r_avg, n_avg;

    t_sample                 v;
    logic signed [SUM_W-1:0] v_ext;
    logic signed [SUM_W:0]   trim_wide;
    logic [SUM_W:0]          mag_wide;
    logic [PROD_W-1:0]       prod;
    logic [MAG_W-1:0]        quo_div;
    logic [MAG_W-1:0]        quo_neg;

    assign v         = t_sample'(r_win[0]);
    assign v_ext     = $signed({{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v});
    assign trim_wide = $signed({r_sum[SUM_W-1], r_sum})
                     - $signed({{(SUM_W + 1 - SAMPLE_W){r_hi[SAMPLE_W-1]}}, r_hi})
                     - $signed({{(SUM_W + 1 - SAMPLE_W){r_lo[SAMPLE_W-1]}}, r_lo});
    assign mag_wide  = trim_wide[SUM_W] ? (SUM_W + 1)'(-trim_wide)
                                        : (SUM_W + 1)'(trim_wide);
    assign prod      = PROD_W'(r_mag) * PROD_W'(RECIP);
    assign quo_div   = MAG_W'(prod >> (MAG_W + DIV_SH));
    assign quo_neg   = '0 - quo_div;

    assign o_average_valid = (r_state == ST_OUT);
    assign o_average_out   = r_avg;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_win   = r_win;
        n_sum   = r_sum;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_avg   = r_avg;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop = i_valid;
                if (i_valid) begin
                    n_win   = i_window;
                    n_sum   = '0;
                    n_hi    = SAMPLE_MIN;
                    n_lo    = SAMPLE_MAX;
                    n_cnt   = CNT_W'(WINDOW);
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_sum = r_sum + v_ext;
                if (v > r_hi) begin
                    n_hi = v;
                end
                if (v < r_lo) begin
                    n_lo = v;
                end
                n_win = {{SAMPLE_W{1'b0}}, r_win[WINDOW-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                n_neg   = trim_wide[SUM_W];
                n_mag   = mag_wide[MAG_W-1:0];
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_avg   = r_neg ? t_sample'(quo_neg[SAMPLE_W-1:0])
                                : t_sample'(quo_div[SAMPLE_W-1:0]);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_average_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_sum <= n_sum;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_avg <= n_avg;
    end

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_cnt != '0)
        else $error("step count ran out inside scan");

    a_pop_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_SCAN && r_cnt == CNT_W'(WINDOW)))
        else $error("pop did not start a full window scan");

    a_hi_ge_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TRIM |-> r_hi >= r_lo)
        else $error("window max below window min");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_average_valid && i_average_stall) |=> (o_average_valid && $stable(o_average_out)))
        else $error("stalled result changed or dropped");

endmodule

// ----- hw/rtl/trimmed_window_average_core.sv -----
// Top level of the trimmed window average filter.
//
// Usage:
//   Sample channel: i_sample_valid / i_sample_in in, o_sample_stall out.
//   A request is taken at a clock edge with valid high and stall low.
//   Result channel: o_average_valid / o_average_out out, i_average_stall in.
//   Each sample gives one result: the mean of the WINDOW newest samples with
//   one largest and one smallest value dropped, truncated toward zero.
//   The window of each request is pushed into the queue; the back end pops
//   it when idle, scans one window entry per cycle, trims, divides by a
//   reciprocal multiply and holds the result until it is taken. It takes a
//   new window only after its last result is taken.
//   A two-entry queue holds windows, so new samples are taken while a result
//   waits; o_sample_stall rises only when that queue is full.
//   Reset (synchronous, active low) zeroes the sample history and empties
//   the queue; the first windows are padded with zeros.
//   While i_average_stall is high the result stays valid and unchanged.
`timescale 1ns / 1ps

module trimmed_window_average_core #(
    parameter int WINDOW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_sample_valid,
    input  twa_pkg::t_sample i_sample_in,
    output logic             o_sample_stall,
    output logic             o_average_valid,
    output twa_pkg::t_sample o_average_out,
    input  logic             i_average_stall
);
    import twa_pkg::*;

    localparam int WIN_W = WINDOW * SAMPLE_W;

    logic                            push;
    logic                            q_full;
    logic                            q_valid;
    logic                            pop;
    logic [WINDOW-1:0][SAMPLE_W-1:0] push_window;
    logic [WIN_W-1:0]                pop_data;

    twa_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .i_sample_in    (i_sample_in),
        .o_sample_stall (o_sample_stall),
        .i_queue_full   (q_full),
        .o_push         (push),
        .o_window       (push_window)
    );

    twa_queue #(
        .DATA_W (WIN_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_window),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_data)
    );

    twa_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_window        (pop_data),
        .o_pop           (pop),
        .o_average_valid (o_average_valid),
        .o_average_out   (o_average_out),
        .i_average_stall (i_average_stall)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the trimmed window average filter core.
`timescale 1ns / 1ps

module tb;

    import twa_pkg::*;

    localparam int WINDOW     = 8;
    localparam int HIST_DEPTH = WINDOW - 1;
    localparam int RAND_ITEMS = 750;
    localparam int MAX_GAP    = 18;
    localparam int DRAIN_MAX  = 20000;
    localparam int TAIL_WAIT  = 120;

    typedef struct {
        t_sample sample;
        bit      known;
        t_sample average;
    } t_dir_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_sample_valid;
    t_sample i_sample_in;
    logic    o_sample_stall;
    logic    o_average_valid;
    t_sample o_average_out;
    logic    i_average_stall;

    t_sample  history [HIST_DEPTH];
    t_sample  expected_averages [$];
    t_dir_row dir_rows [$];
    int       err_count = 0;
    int       send_count;
    int       recv_count = 0;

    trimmed_window_average_core #(
        .WINDOW(WINDOW)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .i_sample_in    (i_sample_in),
        .o_sample_stall (o_sample_stall),
        .o_average_valid(o_average_valid),
        .o_average_out  (o_average_out),
        .i_average_stall(i_average_stall)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // trimmed mean of new sample plus history; shifts the sample in
    function automatic t_sample trim_mean_predict(input t_sample s);
        int hi;
        int lo;
        int total;
        hi    = s;
        lo    = s;
        total = s;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            if (history[k] > hi) hi = history[k];
            if (history[k] < lo) lo = history[k];
            total += history[k];
        end
        for (int k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = s;
        return t_sample'((total - hi - lo) / (WINDOW - 2));
    endfunction

    // idle stretches: every third block of 64 requests runs back to back
    function automatic int pick_gap(input int idx);
        if ((idx / 64) % 3 == 1) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic t_sample random_sample(input t_sample last);
        case ($urandom_range(0, 5))
            0, 4: return t_sample'($urandom);
            1: return $urandom_range(0, 1) ? t_sample'(16'sh7fff) : t_sample'(16'sh8000);
            2: return t_sample'(int'($urandom_range(0, 16)) - 8);
            3: return last;
            default: return $urandom_range(0, 1) ?
                t_sample'(32767 - int'($urandom_range(0, 15))) :
                t_sample'(-32768 + int'($urandom_range(0, 15)));
        endcase
    endfunction

    task automatic add_row(input int s, input bit known, input int avg);
        t_dir_row r;
        r.sample  = t_sample'(s);
        r.known   = known;
        r.average = t_sample'(avg);
        dir_rows.push_back(r);
    endtask

    task automatic send_sample(input t_sample s, input bit known, input t_sample avg);
        t_sample pred;
        int      gap;
        i_sample_valid <= 1'b1;
        i_sample_in    <= s;
        do @(posedge i_clk); while (o_sample_stall);
        pred = trim_mean_predict(s);
        expected_averages.push_back(known ? avg : pred);
        send_count++;
        gap = pick_gap(send_count);
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_average_valid === 1'b1 && i_average_stall === 1'b0) begin
            if (expected_averages.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, o_average_out);
                err_count++;
            end else begin
                if (o_average_out !== expected_averages[0]) begin
                    $display("%0t: average_out mismatch, expected %0d, actual %0d",
                             $time, expected_averages[0], o_average_out);
                    err_count++;
                end
                void'(expected_averages.pop_front());
            end
        end
    end

    initial begin
        int n;
        i_average_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = ((recv_count / 50) % 4 == 2) ? 0 : $urandom_range(0, MAX_GAP);
            if (n > 0) begin
                i_average_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_average_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_average_valid === 1'b1 && !i_average_stall));
            recv_count++;
        end
    end

    initial begin
        t_sample last;
        int      waited;
        i_rst_n         = 1'b0;
        i_sample_valid  = 1'b0;
        i_sample_in     = '0;
        send_count      = 0;
        for (int k = 0; k < HIST_DEPTH; k++) history[k] = '0;

        // zero-padded start, both extremes, all-equal windows, ties, truncation
        add_row(0, 1, 0);
        add_row(32767, 1, 0);
        add_row(-32768, 1, 0);
        for (int k = 0; k < 7; k++) add_row(-32768, k == 6, -32768);
        for (int k = 0; k < 8; k++) add_row(32767, k == 7, 32767);
        add_row(-1, 0, 0);
        add_row(-1, 0, 0);
        add_row(5, 0, 0);
        add_row(-7, 0, 0);
        add_row(3, 0, 0);
        add_row(100, 0, 0);
        add_row(-100, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_sample(dir_rows[i].sample, dir_rows[i].known,
                                          dir_rows[i].average);

        last = '0;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            last = random_sample(last);
            send_sample(last, 0, '0);
        end
        i_sample_valid <= 1'b0;

        waited = 0;
        while (expected_averages.size() != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > DRAIN_MAX) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (expected_averages.size() != 0) begin
            $display("%0t: missing result, expected %0d, actual none",
                     $time, expected_averages[0]);
            err_count++;
        end
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
